// ===== sv/triangle_face_normal_defines.svh =====
// Assertion macros used by the checker file.
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define TFN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define TFN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tfn_pkg.sv =====
`default_nettype none
package tfn_pkg;

  // Vector components handled side by side in every stage.
  localparam int unsigned NUM_AXES = 3;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

endpackage
`default_nettype wire

// ===== sv/triangle_face_normal.sv =====
// Throughput: one face per cycle; the whole pipeline holds while a result beat stalls.
// Normalisation runs a bit-per-stage divider (2*NORMAL_FRAC_BITS + 3 stages) and then a
// bit-per-stage square root (NORMAL_FRAC_BITS + 2 stages), three component lanes each.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
`default_nettype none
module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int unsigned COORD_WIDTH      = 16,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  signed [COORD_WIDTH-1:0]         in_first_x,
  input  wire  signed [COORD_WIDTH-1:0]         in_first_y,
  input  wire  signed [COORD_WIDTH-1:0]         in_first_z,
  input  wire  signed [COORD_WIDTH-1:0]         in_second_x,
  input  wire  signed [COORD_WIDTH-1:0]         in_second_y,
  input  wire  signed [COORD_WIDTH-1:0]         in_second_z,
  input  wire  signed [COORD_WIDTH-1:0]         in_third_x,
  input  wire  signed [COORD_WIDTH-1:0]         in_third_y,
  input  wire  signed [COORD_WIDTH-1:0]         in_third_z,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [NORMAL_FRAC_BITS+1:0]    out_normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0]    out_normal_y,
  output logic signed [NORMAL_FRAC_BITS+1:0]    out_normal_z,
  output logic                                  out_degenerate
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned EW = CW + 1;          // edge
  localparam int unsigned PW = 2 * EW;          // edge product
  localparam int unsigned NW = PW + 1;          // cross component
  localparam int unsigned MW = PW;              // component magnitude
  localparam int unsigned HW = MW / 2;          // magnitude half
  localparam int unsigned SW = 2 * MW;          // squared component
  localparam int unsigned LW = SW + 2;          // squared length
  localparam int unsigned K  = 2 * NORMAL_FRAC_BITS + 2;
  localparam int unsigned QW = K + 1;           // quotient
  localparam int unsigned RW = NORMAL_FRAC_BITS + 2; // square root
  localparam int unsigned OW = NORMAL_FRAC_BITS + 2; // result component

  logic adv;

  // Advance everything unless the result register is held.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage 1: edges ----------------
  logic signed [CW-1:0] p0 [NUM_AXES];
  logic signed [CW-1:0] p1 [NUM_AXES];
  logic signed [CW-1:0] p2 [NUM_AXES];

  assign p0[AXIS_X] = in_first_x;
  assign p0[AXIS_Y] = in_first_y;
  assign p0[AXIS_Z] = in_first_z;
  assign p1[AXIS_X] = in_second_x;
  assign p1[AXIS_Y] = in_second_y;
  assign p1[AXIS_Z] = in_second_z;
  assign p2[AXIS_X] = in_third_x;
  assign p2[AXIS_Y] = in_third_y;
  assign p2[AXIS_Z] = in_third_z;

  logic                 v1_r;
  logic signed [EW-1:0] e01_r [NUM_AXES];
  logic signed [EW-1:0] e02_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  // All three candidate products equal e01 x e02, so only that one is built.
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_edge
    always_ff @(posedge clk) begin
      if (adv) begin
        e01_r[a] <= EW'(p1[a]) - EW'(p0[a]);
        e02_r[a] <= EW'(p2[a]) - EW'(p0[a]);
      end
    end
  end

  // ---------------- stage 2: edge products ----------------
  logic                 v2_r;
  logic signed [PW-1:0] pa_r [NUM_AXES];
  logic signed [PW-1:0] pb_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_prod
    localparam int unsigned J = (a + 1) % NUM_AXES;
    localparam int unsigned L = (a + 2) % NUM_AXES;
    logic signed [PW-1:0] pa_nxt;
    logic signed [PW-1:0] pb_nxt;
    assign pa_nxt = PW'(e01_r[J]) * PW'(e02_r[L]);
    assign pb_nxt = PW'(e01_r[L]) * PW'(e02_r[J]);
    always_ff @(posedge clk) begin
      if (adv) begin
        pa_r[a] <= pa_nxt;
        pb_r[a] <= pb_nxt;
      end
    end
  end

  // ---------------- stage 3: cross product, sign, magnitude ----------------
  logic                 v3_r;
  logic                 deg3_r;
  logic [NUM_AXES-1:0]  neg3_r;
  logic [MW-1:0]        mag3_r [NUM_AXES];
  logic signed [NW-1:0] n_nxt  [NUM_AXES];
  logic [NUM_AXES-1:0]  nz_nxt;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_cross
    logic signed [NW-1:0] neg_n;
    assign n_nxt[a]  = NW'(pa_r[a]) - NW'(pb_r[a]);
    assign neg_n     = -n_nxt[a];
    assign nz_nxt[a] = (n_nxt[a] != '0);
    always_ff @(posedge clk) begin
      if (adv) begin
        neg3_r[a] <= n_nxt[a][NW-1];
        mag3_r[a] <= n_nxt[a][NW-1] ? neg_n[MW-1:0] : n_nxt[a][MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r   <= v2_r;
      deg3_r <= (nz_nxt == '0);
    end
  end

  // ---------------- stage 4: partial squares ----------------
  logic                v4_r;
  logic                deg4_r;
  logic [NUM_AXES-1:0] neg4_r;
  logic [2*HW-1:0]     ll4_r [NUM_AXES];
  logic [2*HW-1:0]     lh4_r [NUM_AXES];
  logic [2*HW-1:0]     hh4_r [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_psq
    logic [HW-1:0] lo_h;
    logic [HW-1:0] hi_h;
    assign lo_h = mag3_r[a][HW-1:0];
    assign hi_h = mag3_r[a][MW-1:HW];
    always_ff @(posedge clk) begin
      if (adv) begin
        ll4_r[a] <= (2*HW)'(lo_h) * (2*HW)'(lo_h);
        lh4_r[a] <= (2*HW)'(lo_h) * (2*HW)'(hi_h);
        hh4_r[a] <= (2*HW)'(hi_h) * (2*HW)'(hi_h);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r   <= v3_r;
      deg4_r <= deg3_r;
      neg4_r <= neg3_r;
    end
  end

  // ---------------- stage 5: component squares ----------------
  logic                v5_r;
  logic                deg5_r;
  logic [NUM_AXES-1:0] neg5_r;
  logic [SW-1:0]       sq5_r [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_sq
    always_ff @(posedge clk) begin
      if (adv) begin
        sq5_r[a] <= (SW'(hh4_r[a]) << (2 * HW)) + (SW'(lh4_r[a]) << (HW + 1))
                    + SW'(ll4_r[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r   <= v4_r;
      deg5_r <= deg4_r;
      neg5_r <= neg4_r;
    end
  end

  // ---------------- stage 6: squared length ----------------
  logic                v6_r;
  logic                deg6_r;
  logic [NUM_AXES-1:0] neg6_r;
  logic [SW-1:0]       sq6_r [NUM_AXES];
  logic [LW-1:0]       len6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r   <= v5_r;
      deg6_r <= deg5_r;
      neg6_r <= neg5_r;
      len6_r <= LW'(sq5_r[AXIS_X]) + LW'(sq5_r[AXIS_Y]) + LW'(sq5_r[AXIS_Z]);
      sq6_r  <= sq5_r;
    end
  end

  // ---------------- divider: floor(c^2 * 2^K / len2), one bit a stage ----------------
  logic                dv_r   [K+1];
  logic                ddeg_r [K+1];
  logic [NUM_AXES-1:0] dneg_r [K+1];
  logic [LW-1:0]       dd_r   [K+1];
  logic [LW-1:0]       drem_r [K+1][NUM_AXES];
  logic [QW-1:0]       dq_r   [K+1][NUM_AXES];

  for (genvar s = 0; s <= K; s++) begin : g_div
    if (s == 0) begin : g_load
      // Load the divisor and side bits from the length stage.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[s] <= 1'b0;
        end else if (adv) begin
          dv_r[s]   <= v6_r;
          ddeg_r[s] <= deg6_r;
          dneg_r[s] <= neg6_r;
          dd_r[s]   <= len6_r;
        end
      end
    end else begin : g_pass
      // Pass the divisor and side bits down the divider.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[s] <= 1'b0;
        end else if (adv) begin
          dv_r[s]   <= dv_r[s-1];
          ddeg_r[s] <= ddeg_r[s-1];
          dneg_r[s] <= dneg_r[s-1];
          dd_r[s]   <= dd_r[s-1];
        end
      end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      logic [LW:0]   trial;
      logic [LW:0]   dvs;
      logic          qbit;
      logic [LW:0]   diff;
      logic [QW-1:0] q_in;

      // Integer part first, then shift-and-subtract for each fraction bit.
      if (s == 0) begin : g_first
        assign trial = (LW+1)'(sq6_r[a]);
        assign dvs   = (LW+1)'(len6_r);
        assign q_in  = '0;
      end else begin : g_step
        assign trial = {drem_r[s-1][a], 1'b0};
        assign dvs   = (LW+1)'(dd_r[s-1]);
        assign q_in  = dq_r[s-1][a];
      end
      assign qbit = (trial >= dvs);
      assign diff = trial - dvs;

      always_ff @(posedge clk) begin
        if (adv) begin
          drem_r[s][a] <= qbit ? diff[LW-1:0] : trial[LW-1:0];
          dq_r[s][a]   <= {q_in[QW-2:0], qbit};
        end
      end
    end
  end

  // ---------------- square root: one root bit a stage ----------------
  logic                sv_r    [RW];
  logic                sdeg_r  [RW];
  logic [NUM_AXES-1:0] sneg_r  [RW];
  logic [QW-1:0]       sval_r  [RW][NUM_AXES];
  logic [RW-1:0]       sroot_r [RW][NUM_AXES];

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    if (j == 0) begin : g_load
      // Take the side bits from the divider output.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sv_r[j] <= 1'b0;
        end else if (adv) begin
          sv_r[j]   <= dv_r[K];
          sdeg_r[j] <= ddeg_r[K];
          sneg_r[j] <= dneg_r[K];
        end
      end
    end else begin : g_pass
      // Pass the side bits down the root stages.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sv_r[j] <= 1'b0;
        end else if (adv) begin
          sv_r[j]   <= sv_r[j-1];
          sdeg_r[j] <= sdeg_r[j-1];
          sneg_r[j] <= sneg_r[j-1];
        end
      end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      logic [QW-1:0]   val_in;
      logic [RW-1:0]   root_in;
      logic [RW-1:0]   cand;
      logic [2*RW-1:0] cand_sq;

      if (j == 0) begin : g_first
        assign val_in  = dq_r[K][a];
        assign root_in = '0;
      end else begin : g_step
        assign val_in  = sval_r[j-1][a];
        assign root_in = sroot_r[j-1][a];
      end
      assign cand    = root_in | (RW'(1) << (RW - 1 - j));
      assign cand_sq = (2*RW)'(cand) * (2*RW)'(cand);

      // Keep the trial bit when its square still fits.
      always_ff @(posedge clk) begin
        if (adv) begin
          sval_r[j][a]  <= val_in;
          sroot_r[j][a] <= (cand_sq <= (2*RW)'(val_in)) ? cand : root_in;
        end
      end
    end
  end

  // ---------------- output: round, sign, degenerate ----------------
  logic                 out_valid_r;
  logic                 out_deg_r;
  logic signed [OW-1:0] out_n_r   [NUM_AXES];
  logic signed [OW-1:0] out_n_nxt [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_out
    logic [RW:0]   half_up;
    logic [OW-1:0] mag_o;
    assign half_up = ({1'b0, sroot_r[RW-1][a]} + (RW+1)'(1)) >> 1;
    assign mag_o   = half_up[OW-1:0];
    always_comb begin
      if (sdeg_r[RW-1]) begin
        out_n_nxt[a] = '0;
      end else if (sneg_r[RW-1][a]) begin
        out_n_nxt[a] = -$signed(mag_o);
      end else begin
        out_n_nxt[a] = $signed(mag_o);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        out_n_r[a] <= out_n_nxt[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sv_r[RW-1];
      out_deg_r   <= sdeg_r[RW-1];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_degenerate = out_deg_r;
  assign out_normal_x   = out_n_r[AXIS_X];
  assign out_normal_y   = out_n_r[AXIS_Y];
  assign out_normal_z   = out_n_r[AXIS_Z];

endmodule
`default_nettype wire

// ===== sv/tfn_checker.sv =====
`default_nettype none
`include "triangle_face_normal_defines.svh"
module tfn_checker #(
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_stall,
  input wire                                out_valid,
  input wire                                out_stall,
  input wire signed [NORMAL_FRAC_BITS+1:0]  out_normal_x,
  input wire signed [NORMAL_FRAC_BITS+1:0]  out_normal_y,
  input wire signed [NORMAL_FRAC_BITS+1:0]  out_normal_z,
  input wire                                out_degenerate
);

  localparam int unsigned OW = NORMAL_FRAC_BITS + 2;
  localparam logic signed [OW-1:0] UNIT = OW'(1) << NORMAL_FRAC_BITS;

  // A degenerate face carries a zero normal.
  `TFN_ASSERT_IMP(a_deg_zero, out_valid && out_degenerate,
    out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0,
    "degenerate beat with non-zero normal")

  // A proper face always has some non-zero component.
  `TFN_ASSERT_IMP(a_nondeg_nonzero, out_valid && !out_degenerate,
    out_normal_x != '0 || out_normal_y != '0 || out_normal_z != '0,
    "proper face with zero normal")

  // Components stay within one unit.
  `TFN_ASSERT_IMP(a_range, out_valid,
    out_normal_x <= UNIT && out_normal_x >= -UNIT &&
    out_normal_y <= UNIT && out_normal_y >= -UNIT &&
    out_normal_z <= UNIT && out_normal_z >= -UNIT,
    "normal component out of range")

  // Input side holds only behind a stalled result beat.
  `TFN_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall,
    "input stalled without a stalled result beat")

  // Stalled result beat holds.
  `TFN_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_normal_x) && $stable(out_normal_y) &&
    $stable(out_normal_z) && $stable(out_degenerate),
    "stalled result beat changed")

endmodule

bind triangle_face_normal tfn_checker #(
  .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
) u_tfn_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_normal_x  (out_normal_x),
  .out_normal_y  (out_normal_y),
  .out_normal_z  (out_normal_z),
  .out_degenerate(out_degenerate)
);
`default_nettype wire

// ===== sim/tb_triangle_face_normal.sv =====
`default_nettype none
module tb_triangle_face_normal;
  import tfn_pkg::*;

  localparam int unsigned CW          = 16;
  localparam int unsigned FRAC        = 14;
  localparam int unsigned NUM_RANDOM  = 950;
  localparam int unsigned LATENCY     = 3 * FRAC + 12;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;

  // Vertex coordinates p0 xyz, p1 xyz, p2 xyz
  typedef logic [8:0][CW-1:0] face_t;
  typedef logic [2:0][63:0] vec_t;

  typedef struct {
    logic signed [FRAC+1:0] nx;
    logic signed [FRAC+1:0] ny;
    logic signed [FRAC+1:0] nz;
    logic                   degen;
  } normal_t;

  // Exact cross product of two integer vectors
  function automatic vec_t cross_vec(vec_t a, vec_t b);
    longint ax, ay, az, bx, by, bz;
    vec_t r;
    ax = $signed(a[AXIS_X]); ay = $signed(a[AXIS_Y]); az = $signed(a[AXIS_Z]);
    bx = $signed(b[AXIS_X]); by = $signed(b[AXIS_Y]); bz = $signed(b[AXIS_Z]);
    r[AXIS_X] = ay * bz - az * by;
    r[AXIS_Y] = az * bx - ax * bz;
    r[AXIS_Z] = ax * by - ay * bx;
    return r;
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] v);
    return $signed(v) < 0 ? -v : v;
  endfunction

  function automatic logic [127:0] len_sq(vec_t n);
    logic [127:0] s, m;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      m = {64'd0, abs64(n[i])};
      s = s + m * m;
    end
    return s;
  endfunction

  // Largest r in 0..2^FRAC with (2r-1)^2 * len2 <= 4 * a^2 * 2^(2*FRAC)
  function automatic logic [63:0] unit_mag(logic [63:0] a, logic [127:0] len2);
    logic [127:0] rhs, t, lhs, aw;
    longint lo, hi, mid;
    aw  = {64'd0, a};
    rhs = (aw * aw) << (2 * FRAC + 2);
    lo  = 0;
    hi  = longint'(1) << FRAC;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t   = 128'(2 * mid - 1);
      lhs = t * t * len2;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return 64'(lo);
  endfunction

  // Predict the unit normal of one face
  function automatic normal_t face_normal(face_t f);
    vec_t e01, e02, e12, n;
    vec_t c [3];
    logic [127:0] l [3];
    logic [63:0] r;
    normal_t res;
    int k;
    logic degen;
    for (int i = 0; i < 3; i++) begin
      e01[i] = 64'($signed(f[3 + i])) - 64'($signed(f[i]));
      e02[i] = 64'($signed(f[6 + i])) - 64'($signed(f[i]));
      e12[i] = 64'($signed(f[6 + i])) - 64'($signed(f[3 + i]));
    end
    c[0] = cross_vec(e01, e02);
    c[1] = cross_vec(e02, e12);
    c[2] = cross_vec(e01, e12);
    degen = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (c[j] == '0) degen = 1'b1;
      l[j] = len_sq(c[j]);
    end
    res = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
    if (degen) return res;
    // Ties fall to the later candidate
    if (l[0] > l[1] && l[0] > l[2]) k = 0;
    else if (l[1] > l[2]) k = 1;
    else k = 2;
    n = c[k];
    res.degen = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r = unit_mag(abs64(n[i]), l[k]);
      if ($signed(n[i]) < 0) r = -r;
      case (i)
        AXIS_X: res.nx = r[FRAC+1:0];
        AXIS_Y: res.ny = r[FRAC+1:0];
        default: res.nz = r[FRAC+1:0];
      endcase
    end
    return res;
  endfunction

  class face_normal_board;
    normal_t pending_normals [$];
    int      errors;
    int      faces;
    int      degen_faces;

    function new();
      errors = 0;
      faces = 0;
      degen_faces = 0;
    endfunction

    function void note_face(face_t f);
      normal_t e;
      e = face_normal(f);
      faces++;
      if (e.degen) degen_faces++;
      pending_normals.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d (face result %0d)",
               what, got, want, faces - pending_normals.size());
      errors++;
    endtask

    task check_normal(normal_t got);
      normal_t want;
      if (pending_normals.size() == 0) begin
        report("unexpected result beat", 1, 0);
        return;
      end
      want = pending_normals.pop_front();
      if (got.nx !== want.nx) report("normal_x", got.nx, want.nx);
      if (got.ny !== want.ny) report("normal_y", got.ny, want.ny);
      if (got.nz !== want.nz) report("normal_z", got.nz, want.nz);
      if (got.degen !== want.degen) report("degenerate", got.degen, want.degen);
    endtask

    function int outstanding();
      return pending_normals.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [CW-1:0] in_first_x, in_first_y, in_first_z;
  logic signed [CW-1:0] in_second_x, in_second_y, in_second_z;
  logic signed [CW-1:0] in_third_x, in_third_y, in_third_z;
  logic out_valid;
  logic out_stall;
  logic signed [FRAC+1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate;

  face_normal_board board;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int unsigned cycles;

  triangle_face_normal #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_first_x(in_first_x), .in_first_y(in_first_y), .in_first_z(in_first_z),
    .in_second_x(in_second_x), .in_second_y(in_second_y), .in_second_z(in_second_z),
    .in_third_x(in_third_x), .in_third_y(in_third_y), .in_third_z(in_third_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_degenerate(out_degenerate)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort on a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("triangle_face_normal test failed");
      $finish;
    end
  end

  // Drive result stall: long hold-off on request, else random
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (rst_n && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Check every accepted result beat
  initial begin
    normal_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = '{nx: out_normal_x, ny: out_normal_y, nz: out_normal_z,
                degen: out_degenerate};
        board.check_normal(got);
      end
    end
  end

  // Offer one face and hold it until accepted
  task send_face(face_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_first_x  <= f[0]; in_first_y  <= f[1]; in_first_z  <= f[2];
    in_second_x <= f[3]; in_second_y <= f[4]; in_second_z <= f[5];
    in_third_x  <= f[6]; in_third_y  <= f[7]; in_third_z  <= f[8];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_face(f);
  endtask

  // Drop valid and wait for every outstanding result
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord(int unsigned mode);
    logic [CW-1:0] v;
    case (mode)
      0: v = CW'($urandom);
      1: v = CW'($signed($urandom_range(8)) - 4);
      2: begin
        case ($urandom_range(3))
          0: v = {1'b1, {(CW-1){1'b0}}};
          1: v = {1'b0, {(CW-1){1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = CW'($signed($urandom_range(512)) - 256);
    endcase
    return v;
  endfunction

  function automatic face_t rand_face();
    face_t f;
    int unsigned mode;
    int unsigned pick;
    mode = $urandom_range(9);
    mode = (mode < 5) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
    for (int i = 0; i < 9; i++) f[i] = rand_coord(mode);
    // Now and then repeat a vertex or make the face collinear
    pick = $urandom_range(19);
    if (pick == 0) for (int i = 0; i < 3; i++) f[6 + i] = f[3 + i];
    else if (pick == 1) for (int i = 0; i < 3; i++) f[3 + i] = f[i];
    else if (pick == 2)
      for (int i = 0; i < 3; i++) f[6 + i] = CW'(2 * f[3 + i] - f[i]);
    return f;
  endfunction

  function automatic face_t mk(int a0, int a1, int a2, int b0, int b1, int b2,
                               int c0, int c1, int c2);
    face_t f;
    f[0] = CW'(a0); f[1] = CW'(a1); f[2] = CW'(a2);
    f[3] = CW'(b0); f[4] = CW'(b1); f[5] = CW'(b2);
    f[6] = CW'(c0); f[7] = CW'(c1); f[8] = CW'(c2);
    return f;
  endfunction

  initial begin
    face_t directed [$];
    board = new();
    send_idle_pct  = 11;
    recv_stall_pct = 73;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_first_x, in_first_y, in_first_z} = '0;
    {in_second_x, in_second_y, in_second_z} = '0;
    {in_third_x, in_third_y, in_third_z} = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Axis-aligned faces, both windings
    directed.push_back(mk(0, 0, 0, 256, 0, 0, 0, 256, 0));
    directed.push_back(mk(0, 0, 0, 0, 256, 0, 256, 0, 0));
    directed.push_back(mk(0, 0, 0, 0, 0, 256, 256, 0, 0));
    directed.push_back(mk(0, 0, 0, 0, 1, 0, 0, 0, 1));
    // Degenerate: repeated vertex, all equal, collinear
    directed.push_back(mk(5, 6, 7, 5, 6, 7, 9, 1, 3));
    directed.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768));
    directed.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767));
    directed.push_back(mk(0, 0, 0, 1, 2, 3, 2, 4, 6));
    directed.push_back(mk(-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767));
    // Largest products from extreme coordinates
    directed.push_back(mk(-32768, -32768, -32768, 32767, -32768, -32768,
                          -32768, 32767, -32768));
    directed.push_back(mk(-32768, 32767, -32768, 32767, -32768, 32767,
                          -32768, -32768, 32767));
    directed.push_back(mk(32767, -32768, 32767, -32768, 32767, -32768,
                          32767, 32767, -32768));
    // Equal-length products: selection tie
    directed.push_back(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
    directed.push_back(mk(3, -2, 1, -1, 4, -5, 2, 2, -7));
    // Diagonal normals and rounding on small values
    directed.push_back(mk(1, 0, 0, 0, 1, 0, 0, 0, 1));
    directed.push_back(mk(0, 0, 0, 1, 1, 0, 0, 1, 1));
    directed.push_back(mk(-1, -1, -1, 2, -1, 0, -1, 3, 1));
    directed.push_back(mk(100, -200, 300, -400, 500, -600, 700, -800, 901));
    foreach (directed[i]) send_face(directed[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) begin
        // Empty the pipe before swapping the idle ratios
        drain();
        send_idle_pct  = 73;
        recv_stall_pct = 11;
      end
      if (n == 2 * NUM_RANDOM / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Back-pressure long enough to fill the pipe
        hold_req = 1'b1;
      end
      send_face(rand_face());
    end

    drain();
    repeat (LATENCY + 8) @(posedge clk);
    $display("covered %0d faces (%0d degenerate) under three idle patterns",
             board.faces, board.degen_faces);
    $display("with a %0d-cycle result hold-off and a mid-run drain", HOLD_CYCLES);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("triangle_face_normal test passed");
    end else begin
      $display("triangle_face_normal test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
